FILE: design/sttm_pkg.sv
`default_nettype none

package sttm_pkg;

   // Field widths of the request and response transactions.
   localparam int FREQ_W     = 19;
   localparam int STEP_W     = 12;
   localparam int AMP_W      = 13;
   localparam int NOTE_W     = 12;
   localparam int SAMPLE_W   = 16;
   localparam int BYTE_W     = 8;
   localparam int VOICE_W    = AMP_W + 1;
   localparam int CSR_DATA_W = 13;
   localparam int CSR_IDX_W  = 1;

   localparam int SAMPLE_RATE_HZ_DEFAULT = 8000;

   localparam logic [AMP_W-1:0]  AMP_RESET  = 13'd500;
   localparam logic [NOTE_W-1:0] NOTE_RESET = 12'd1200;

   // Pipeline layout. The envelope divider is the longest path: one setup
   // stage plus one stage per quotient bit.
   localparam int PHASE_STAGES = 4;
   localparam int TRI_STAGES   = 4;
   localparam int ENV_STAGES   = AMP_W + 1;
   localparam int PIPE_STAGES  = ENV_STAGES + 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AMPLITUDE  = 1'b0,
      CSR_NOTE_STEPS = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [FREQ_W-1:0] square1_freq;
      logic [FREQ_W-1:0] square2_freq;
      logic [FREQ_W-1:0] triangle_freq;
      logic [STEP_W-1:0] step_in_note;
   } sttm_req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] mixed_sample;
      logic signed [BYTE_W-1:0]   sample_byte;
   } sttm_rsp_type;

   // Per-voice result of a square voice's phase: whether the voice sounds
   // and whether it is in the negative half of its period.
   typedef struct packed {
      logic active;
      logic odd;
   } sttm_sq_tag_type;

endpackage

`default_nettype wire

FILE: design/square_triangle_tone_mixer.sv
// Square/triangle tone mixer: one audio sample per request transaction.
//
// Request channel (req_valid/req_ready/req_data) carries three voice
// frequencies in centihertz (zero silences a voice) and the sample's step
// within the note. Response channel (rsp_valid/rsp_ready/rsp_data) returns
// the mixed sample and that sample shifted right arithmetically by eight.
// The CSR channel (csr_valid/csr_ready/csr_index/csr_wdata) is always ready
// and writes the voice amplitude or the note length; write it only while no
// transaction is in flight.
//
// The datapath is a 15-stage pipeline. While the response side never stalls,
// one transaction enters per cycle. The depth is set by the envelope
// divider, which resolves one quotient bit per stage.
// When rsp_ready is low, the pipeline keeps accepting requests until every
// stage holds a transaction; then req_ready drops until the response drains.
// Reset empties the pipeline and loads amplitude 500 and note length 1200.

`default_nettype none

module square_triangle_tone_mixer
   import sttm_pkg::*;
#(
   parameter int SAMPLE_RATE_HZ = SAMPLE_RATE_HZ_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire sttm_req_type          req_data,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      sttm_rsp_type          rsp_data,
   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire csr_index_type         csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam longint unsigned DEN = 64'(100 * SAMPLE_RATE_HZ);
   localparam int RES_W = $clog2(DEN);

   // Square-voice tags wait from the end of the phase stages until the
   // envelope is ready; the triangle value waits from the end of its own.
   localparam int SQ_DLY  = ENV_STAGES - PHASE_STAGES;
   localparam int TRI_DLY = ENV_STAGES - PHASE_STAGES - TRI_STAGES;

   typedef struct packed {
      sttm_sq_tag_type sq1;
      sttm_sq_tag_type sq2;
   } sq_pair_type;

   // Configuration registers.
   logic [AMP_W-1:0]  amp_ff, amp_in;
   logic [NOTE_W-1:0] notes_ff, notes_in;

   logic [PIPE_STAGES-1:0] stage_en;

   sttm_sq_tag_type sq1_tag;
   sttm_sq_tag_type sq2_tag;
   logic [RES_W-1:0] tri_rem;
   logic signed [VOICE_W-1:0] tri_val;
   logic [AMP_W-1:0] env_mag;

   sq_pair_type sq_dly_ff [SQ_DLY];
   sq_pair_type sq_dly_in [SQ_DLY];
   logic signed [VOICE_W-1:0] tri_dly_ff [TRI_DLY];
   logic signed [VOICE_W-1:0] tri_dly_in [TRI_DLY];

   sttm_rsp_type rsp_ff, rsp_in;

   logic signed [SAMPLE_W-1:0] mag_w;
   logic signed [SAMPLE_W-1:0] sq1_val;
   logic signed [SAMPLE_W-1:0] sq2_val;
   logic signed [SAMPLE_W-1:0] mix;

   // The CSR channel never back-pressures.
   assign csr_ready = 1'b1;

   always_comb begin
      amp_in   = amp_ff;
      notes_in = notes_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_AMPLITUDE:  amp_in   = csr_wdata[AMP_W-1:0];
            CSR_NOTE_STEPS: notes_in = csr_wdata[NOTE_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_ff   <= AMP_RESET;
         notes_ff <= NOTE_RESET;
      end else begin
         amp_ff   <= amp_in;
         notes_ff <= notes_in;
      end
   end

   // Valid bits and per-stage load enables for the whole pipeline.
   sttm_flow #(
      .STAGES(PIPE_STAGES)
   ) u_flow (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .stage_en (stage_en)
   );

   // Phase of each voice: remainder of f*step modulo 100*SAMPLE_RATE_HZ.
   sttm_phase #(
      .SAMPLE_RATE_HZ(SAMPLE_RATE_HZ)
   ) u_phase_sq1 (
      .clock    (clock),
      .stage_en (stage_en[PHASE_STAGES-1:0]),
      .freq     (req_data.square1_freq),
      .step     (req_data.step_in_note),
      .phase_rem(),
      .tag      (sq1_tag)
   );

   sttm_phase #(
      .SAMPLE_RATE_HZ(SAMPLE_RATE_HZ)
   ) u_phase_sq2 (
      .clock    (clock),
      .stage_en (stage_en[PHASE_STAGES-1:0]),
      .freq     (req_data.square2_freq),
      .step     (req_data.step_in_note),
      .phase_rem(),
      .tag      (sq2_tag)
   );

   sttm_phase #(
      .SAMPLE_RATE_HZ(SAMPLE_RATE_HZ)
   ) u_phase_tri (
      .clock    (clock),
      .stage_en (stage_en[PHASE_STAGES-1:0]),
      .freq     (req_data.triangle_freq),
      .step     (req_data.step_in_note),
      .phase_rem(tri_rem),
      .tag      ()
   );

   // Triangle level from its phase remainder. A silent triangle has a zero
   // remainder and therefore contributes zero.
   sttm_tri #(
      .SAMPLE_RATE_HZ(SAMPLE_RATE_HZ)
   ) u_tri (
      .clock    (clock),
      .stage_en (stage_en[PHASE_STAGES +: TRI_STAGES]),
      .phase_rem(tri_rem),
      .amplitude(amp_ff),
      .tri_val  (tri_val)
   );

   // Shared square envelope, which depends only on the step and the CSRs.
   sttm_env u_env (
      .clock     (clock),
      .stage_en  (stage_en[ENV_STAGES-1:0]),
      .step      (req_data.step_in_note),
      .amplitude (amp_ff),
      .note_steps(notes_ff),
      .env_mag   (env_mag)
   );

   // Alignment delays so that every voice reaches the mixer together.
   always_comb begin
      sq_dly_in[0].sq1 = sq1_tag;
      sq_dly_in[0].sq2 = sq2_tag;
      for (int k = 1; k < SQ_DLY; k++) begin
         sq_dly_in[k] = sq_dly_ff[k-1];
      end
      tri_dly_in[0] = tri_val;
      for (int k = 1; k < TRI_DLY; k++) begin
         tri_dly_in[k] = tri_dly_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < SQ_DLY; k++) begin
         if (stage_en[PHASE_STAGES + k]) begin
            sq_dly_ff[k] <= sq_dly_in[k];
         end
      end
      for (int k = 0; k < TRI_DLY; k++) begin
         if (stage_en[PHASE_STAGES + TRI_STAGES + k]) begin
            tri_dly_ff[k] <= tri_dly_in[k];
         end
      end
   end

   // Mixer: each square voice takes the envelope with the sign of its phase
   // half; a silent square voice contributes nothing.
   assign mag_w = $signed(SAMPLE_W'(env_mag));

   always_comb begin
      if (!sq_dly_ff[SQ_DLY-1].sq1.active) begin
         sq1_val = '0;
      end else if (sq_dly_ff[SQ_DLY-1].sq1.odd) begin
         sq1_val = -mag_w;
      end else begin
         sq1_val = mag_w;
      end
      if (!sq_dly_ff[SQ_DLY-1].sq2.active) begin
         sq2_val = '0;
      end else if (sq_dly_ff[SQ_DLY-1].sq2.odd) begin
         sq2_val = -mag_w;
      end else begin
         sq2_val = mag_w;
      end
   end

   // Three voices of at most 8191 each cannot overflow 16 bits.
   assign mix = sq1_val + sq2_val + SAMPLE_W'(tri_dly_ff[TRI_DLY-1]);

   assign rsp_in.mixed_sample = mix;
   assign rsp_in.sample_byte  = mix[SAMPLE_W-1 -: BYTE_W];

   always_ff @(posedge clock) begin
      if (stage_en[PIPE_STAGES-1]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

FILE: design/sttm_flow.sv
`default_nettype none

module sttm_flow
   import sttm_pkg::*;
#(
   parameter int STAGES = PIPE_STAGES
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      logic [STAGES-1:0] stage_en
);

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;

   // A stage may load when it or any stage after it is empty, or when the
   // last stage is being drained, so bubbles are squeezed out.
   always_comb begin
      logic [STAGES-1:0] low_mask;
      low_mask = '0;
      for (int i = 0; i < STAGES; i++) begin
         low_mask    = ~({STAGES{1'b1}} << i);
         stage_en[i] = rsp_ready || !(&(valid_ff | low_mask));
      end
   end

   assign valid_in = (stage_en & {valid_ff[STAGES-2:0], req_valid}) | (~stage_en & valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = stage_en[0];
   assign rsp_valid = valid_ff[STAGES-1];

endmodule

`default_nettype wire

FILE: design/sttm_phase.sv
`default_nettype none

module sttm_phase
   import sttm_pkg::*;
#(
   parameter  int SAMPLE_RATE_HZ = SAMPLE_RATE_HZ_DEFAULT,
   localparam longint unsigned DEN = 64'(100 * SAMPLE_RATE_HZ),
   localparam int RES_W = $clog2(DEN)
) (
   input  wire logic                    clock,
   input  wire logic [PHASE_STAGES-1:0] stage_en,
   input  wire logic [FREQ_W-1:0]       freq,
   input  wire logic [STEP_W-1:0]       step,
   output      logic [RES_W-1:0]        phase_rem,
   output      sttm_sq_tag_type         tag
);

   // The phase product f*s is reduced modulo DEN with a reciprocal multiply
   // that may undershoot the quotient by one, fixed by one compare-subtract.
   localparam int X_W = FREQ_W + STEP_W;
   localparam longint unsigned RECIP = (64'd1 << X_W) / DEN;
   localparam int RECIP_W = $clog2(RECIP + 1);
   localparam int QUO_W = $clog2(((64'd1 << X_W) - 1) / DEN + 1);
   localparam int P_W = X_W + RECIP_W;
   localparam int T_W = QUO_W + RES_W;
   localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);
   localparam logic [RES_W-1:0]   DEN_V   = RES_W'(DEN);

   logic [X_W-1:0]   x_ff, x_in;
   logic [P_W-1:0]   prod_ff, prod_in;
   logic [X_W-1:0]   x1_ff;
   logic [X_W-1:0]   sub_ff, sub_in;
   logic [X_W-1:0]   x2_ff;
   logic [RES_W-1:0] rem_ff, rem_in;
   logic [PHASE_STAGES-1:0] act_ff;
   logic [PHASE_STAGES-1:0] act_in;

   logic [QUO_W-1:0] quo_est;
   logic [X_W-1:0]   diff;
   logic [RES_W:0]   rem_est;

   assign x_in    = X_W'(freq) * X_W'(step);
   assign prod_in = P_W'(x_ff) * P_W'(RECIP_V);
   assign quo_est = prod_ff[X_W +: QUO_W];
   assign sub_in  = X_W'(T_W'(quo_est) * T_W'(DEN_V));
   assign diff    = x2_ff - sub_ff;
   assign rem_est = diff[RES_W:0];
   assign rem_in  = (rem_est >= {1'b0, DEN_V}) ? RES_W'(rem_est - {1'b0, DEN_V})
                                               : rem_est[RES_W-1:0];
   assign act_in  = {act_ff[PHASE_STAGES-2:0], (freq != '0)};

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         x_ff <= x_in;
      end
      if (stage_en[1]) begin
         prod_ff <= prod_in;
         x1_ff   <= x_ff;
      end
      if (stage_en[2]) begin
         sub_ff <= sub_in;
         x2_ff  <= x1_ff;
      end
      if (stage_en[3]) begin
         rem_ff <= rem_in;
      end
      for (int i = 0; i < PHASE_STAGES; i++) begin
         if (stage_en[i]) begin
            act_ff[i] <= act_in[i];
         end
      end
   end

   // floor(2*f*s/DEN) is odd exactly when twice the remainder reaches DEN.
   assign phase_rem  = rem_ff;
   assign tag.active = act_ff[PHASE_STAGES-1];
   assign tag.odd    = ({rem_ff, 1'b0} >= {1'b0, DEN_V});

endmodule

`default_nettype wire

FILE: design/sttm_tri.sv
`default_nettype none

module sttm_tri
   import sttm_pkg::*;
#(
   parameter  int SAMPLE_RATE_HZ = SAMPLE_RATE_HZ_DEFAULT,
   localparam longint unsigned DEN = 64'(100 * SAMPLE_RATE_HZ),
   localparam int RES_W = $clog2(DEN)
) (
   input  wire logic                     clock,
   input  wire logic [TRI_STAGES-1:0]    stage_en,
   input  wire logic [RES_W-1:0]         phase_rem,
   input  wire logic [AMP_W-1:0]         amplitude,
   output      logic signed [VOICE_W-1:0] tri_val
);

   // Every segment of the triangle is floor(A*u/DEN) with 0 <= u <= DEN.
   // The division is a reciprocal multiply on the top bits of A*u followed
   // by one correction step.
   localparam int C_W = RES_W + 3;
   localparam int U_W = RES_W + 1;
   localparam int Y_W = AMP_W + U_W;
   localparam int SH = AMP_W;
   localparam int K_SH = Y_W + 1;
   localparam longint unsigned RECIP = (64'd1 << K_SH) / DEN;
   localparam int RECIP_W = $clog2(RECIP + 1);
   localparam int HI_W = Y_W - SH;
   localparam int P_W = HI_W + RECIP_W;
   localparam int T_W = AMP_W + RES_W;
   localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);
   localparam logic [RES_W-1:0]   DEN_V   = RES_W'(DEN);
   localparam logic [C_W-1:0] D1 = C_W'(DEN);
   localparam logic [C_W-1:0] D2 = C_W'(2 * DEN);
   localparam logic [C_W-1:0] D3 = C_W'(3 * DEN);
   localparam logic [C_W-1:0] D4 = C_W'(4 * DEN);

   logic [C_W-1:0] r4;
   logic [C_W-1:0] u_wide;
   logic           neg_c;

   logic [Y_W-1:0]   y_ff, y_in;
   logic [P_W-1:0]   p_ff, p_in;
   logic [Y_W-1:0]   y1_ff, y2_ff;
   logic [T_W-1:0]   t_ff, t_in;
   logic [AMP_W-1:0] qe_ff;
   logic [AMP_W-1:0] qe_c;
   logic [2:0]       neg_ff;
   logic signed [VOICE_W-1:0] val_ff, val_in;

   logic [Y_W-1:0]   diff;
   logic [RES_W:0]   rem;
   logic [AMP_W-1:0] mag;

   assign r4 = C_W'(phase_rem) << 2;

   always_comb begin
      if (r4 <= D1) begin
         u_wide = r4;
         neg_c  = 1'b0;
      end else if (r4 <= D2) begin
         u_wide = D2 - r4;
         neg_c  = 1'b0;
      end else if (r4 <= D3) begin
         u_wide = r4 - D2;
         neg_c  = 1'b1;
      end else begin
         u_wide = D4 - r4;
         neg_c  = 1'b1;
      end
   end

   assign y_in = Y_W'(amplitude) * Y_W'(u_wide[U_W-1:0]);
   assign p_in = P_W'(y_ff[Y_W-1:SH]) * P_W'(RECIP_V);
   assign qe_c = p_ff[(K_SH - SH) +: AMP_W];
   assign t_in = T_W'(qe_c) * T_W'(DEN_V);

   assign diff   = y2_ff - Y_W'(t_ff);
   assign rem    = diff[RES_W:0];
   assign mag    = (rem >= {1'b0, DEN_V}) ? qe_ff + AMP_W'(1) : qe_ff;
   assign val_in = neg_ff[2] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         y_ff      <= y_in;
         neg_ff[0] <= neg_c;
      end
      if (stage_en[1]) begin
         p_ff      <= p_in;
         y1_ff     <= y_ff;
         neg_ff[1] <= neg_ff[0];
      end
      if (stage_en[2]) begin
         t_ff      <= t_in;
         qe_ff     <= qe_c;
         y2_ff     <= y1_ff;
         neg_ff[2] <= neg_ff[1];
      end
      if (stage_en[3]) begin
         val_ff <= val_in;
      end
   end

   assign tri_val = val_ff;

endmodule

`default_nettype wire

FILE: design/sttm_env.sv
`default_nettype none

module sttm_env
   import sttm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic [ENV_STAGES-1:0] stage_en,
   input  wire logic [STEP_W-1:0]     step,
   input  wire logic [AMP_W-1:0]      amplitude,
   input  wire logic [NOTE_W-1:0]     note_steps,
   output      logic [AMP_W-1:0]      env_mag
);

   // The falling part is floor(5*(n-s)*A / (3*n)), found by a restoring
   // divider with one quotient bit per stage. The quotient stays below A.
   localparam int QB    = AMP_W;
   localparam int S5_W  = STEP_W + 3;
   localparam int NUM_W = S5_W + AMP_W;
   localparam int DIV_W = NOTE_W + 2;

   typedef enum logic [1:0] {
      ENV_FULL,
      ENV_FALL,
      ENV_MUTE
   } env_mode_type;

   logic [NOTE_W-1:0] n_eff;
   logic [S5_W-1:0]   five_s;
   logic [S5_W-1:0]   two_n;
   logic [NOTE_W-1:0] span;
   env_mode_type      mode_c;
   logic [NUM_W-1:0]  num_c;
   logic [DIV_W-1:0]  div_c;

   logic [NUM_W-1:0] rem_ff  [QB+1];
   logic [QB-1:0]    quo_ff  [QB+1];
   logic [DIV_W-1:0] div_ff  [QB+1];
   env_mode_type     mode_ff [QB+1];

   assign n_eff  = (note_steps == '0) ? NOTE_W'(1) : note_steps;
   assign five_s = S5_W'(step) * S5_W'(5);
   assign two_n  = S5_W'(n_eff) << 1;
   assign span   = n_eff - step;
   assign num_c  = NUM_W'(S5_W'(span) * S5_W'(5)) * NUM_W'(amplitude);
   assign div_c  = DIV_W'(n_eff) * DIV_W'(3);

   always_comb begin
      if (five_s <= two_n) begin
         mode_c = ENV_FULL;
      end else if (step < n_eff) begin
         mode_c = ENV_FALL;
      end else begin
         mode_c = ENV_MUTE;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         rem_ff[0]  <= num_c;
         quo_ff[0]  <= '0;
         div_ff[0]  <= div_c;
         mode_ff[0] <= mode_c;
      end
   end

   for (genvar j = 1; j <= QB; j++) begin : g_div
      logic [NUM_W-1:0] trial;
      logic [NUM_W-1:0] rem_in;
      logic [QB-1:0]    quo_in;

      assign trial = NUM_W'(div_ff[j-1]) << (QB - j);

      always_comb begin
         if (rem_ff[j-1] >= trial) begin
            rem_in = rem_ff[j-1] - trial;
            quo_in = quo_ff[j-1] | (QB'(1) << (QB - j));
         end else begin
            rem_in = rem_ff[j-1];
            quo_in = quo_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en[j]) begin
            rem_ff[j]  <= rem_in;
            quo_ff[j]  <= quo_in;
            div_ff[j]  <= div_ff[j-1];
            mode_ff[j] <= mode_ff[j-1];
         end
      end
   end

   always_comb begin
      unique case (mode_ff[QB])
         ENV_FULL: env_mag = amplitude;
         ENV_FALL: env_mag = quo_ff[QB];
         ENV_MUTE: env_mag = '0;
         default:  env_mag = '0;
      endcase
   end

endmodule

`default_nettype wire

FILE: design/sttm_checker.sv
`default_nettype none

module sttm_checker
   import sttm_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire sttm_req_type          req_data,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire sttm_rsp_type          rsp_data,
   input wire logic                  csr_valid,
   input wire logic                  csr_ready,
   input wire csr_index_type         csr_index,
   input wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // A stalled response transaction holds until it is taken.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // The pipeline comes out of reset empty.
   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // With no response pending, every stage can move, so requests are taken.
   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with an empty output");

   // The byte output is the top byte of the mixed sample.
   a_byte_match : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.sample_byte == rsp_data.mixed_sample[15:8])
      else $error("sample byte does not match mixed sample");

   // Three voices never exceed three times the largest amplitude, 8191.
   a_mix_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_data.mixed_sample) <= 16'sd24573) &&
                    ($signed(rsp_data.mixed_sample) >= -16'sd24573))
      else $error("mixed sample out of range");

endmodule

bind square_triangle_tone_mixer sttm_checker u_sttm_checker (.*);

`default_nettype wire
